// ----- design/tlws_pkg.sv -----
package tlws_pkg;

    // Field widths fixed by the record format.
    localparam int BYTE_BITS      = 8;
    localparam int LINE_BITS      = 16;
    localparam int OFFSET_BITS    = 24;
    localparam int WIDTH_BITS     = 12;
    localparam int LIMIT_BITS     = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    // Default width of the internal text offsets.
    localparam int POS_BITS_DEFAULT = 24;

    // Depth of the queue between the classifier and the segment engine.
    localparam int QUEUE_DEPTH = 4;

    // Byte values that steer the segmentation.
    localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [BYTE_BITS-1:0] PRINT_LOW    = 8'd32;
    localparam logic [BYTE_BITS-1:0] PRINT_HIGH   = 8'd127;

    // Register reset values.
    localparam logic [WIDTH_BITS-1:0]  WRAP_WIDTH_RESET   = 12'd80;
    localparam logic [OFFSET_BITS-1:0] START_POS_RESET    = 24'd0;
    localparam logic [LIMIT_BITS-1:0]  MAX_SEGMENTS_RESET = 16'hFFFF;
    localparam logic [LIMIT_BITS-1:0]  MAX_LINES_RESET    = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WRAP_WIDTH     = 2'd0,
        REG_START_POSITION = 2'd1,
        REG_MAX_SEGMENTS   = 2'd2,
        REG_MAX_LINES      = 2'd3
    } cfg_reg_t;

    // Class of one input item as seen by the segment engine.
    typedef enum logic [1:0] {
        KIND_END     = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_PRINT   = 2'd2,
        KIND_OTHER   = 2'd3
    } item_kind_t;

    // Settings the segment engine reads every cycle.
    typedef struct packed {
        logic [WIDTH_BITS-1:0] wrap_width;
        logic [LIMIT_BITS-1:0] max_segments;
        logic [LIMIT_BITS-1:0] max_lines;
    } engine_cfg_t;

    // Run restart request from a write of the start position.
    typedef struct packed {
        logic                   valid;
        logic [OFFSET_BITS-1:0] position;
    } restart_t;

    // Queue occupancy flags.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- design/tlws_in_if.sv -----
interface tlws_in_if;
    logic                           valid;
    logic                           ready;
    logic [tlws_pkg::BYTE_BITS-1:0] text_byte;
    logic                           end_marker;

    modport source (output valid, output text_byte, output end_marker, input ready);
    modport sink (input valid, input text_byte, input end_marker, output ready);
endinterface

// ----- design/tlws_out_if.sv -----
interface tlws_out_if;
    logic                             valid;
    logic                             ready;
    logic [tlws_pkg::LINE_BITS-1:0]   line_number;
    logic [tlws_pkg::OFFSET_BITS-1:0] segment_start;
    logic [tlws_pkg::OFFSET_BITS-1:0] segment_length;
    logic                             run_done;

    modport source (output valid, output line_number, output segment_start,
                    output segment_length, output run_done, input ready);
    modport sink (input valid, input line_number, input segment_start,
                  input segment_length, input run_done, output ready);
endinterface

// ----- design/tlws_front.sv -----
module tlws_front
(
    tlws_in_if.sink                   text_in,
    input  tlws_pkg::queue_status_t   q_status,
    output logic                      push,
    output tlws_pkg::item_kind_t      push_kind
);

    // Take a byte whenever the queue has room.
    assign text_in.ready = !q_status.full;
    assign push          = text_in.valid && text_in.ready;

    // Sort the item into end, newline, printable or other.
    always_comb
    begin
        if (text_in.end_marker)
        begin
            push_kind = tlws_pkg::KIND_END;
        end
        else if (text_in.text_byte == tlws_pkg::NEWLINE_BYTE)
        begin
            push_kind = tlws_pkg::KIND_NEWLINE;
        end
        else if (text_in.text_byte >= tlws_pkg::PRINT_LOW &&
                 text_in.text_byte <= tlws_pkg::PRINT_HIGH)
        begin
            push_kind = tlws_pkg::KIND_PRINT;
        end
        else
        begin
            push_kind = tlws_pkg::KIND_OTHER;
        end
    end

endmodule

// ----- design/tlws_queue.sv -----
module tlws_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tlws_pkg::item_kind_t    push_kind,
    input  logic                    pop,
    output tlws_pkg::item_kind_t    head_kind,
    output tlws_pkg::queue_status_t status
);

    localparam int DEPTH    = tlws_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    tlws_pkg::item_kind_t   entry_reg [DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg;
    logic [PTR_BITS-1:0]    rd_ptr_reg;
    logic [CNT_BITS-1:0]    count_reg;

    // Occupancy flags and head of the queue.
    assign status.full  = (count_reg == CNT_BITS'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_kind    = entry_reg[rd_ptr_reg];

    // Entry storage; only written, never cleared.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_kind;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/tlws_back.sv -----
module tlws_back
#(
    parameter int POS_BITS = tlws_pkg::POS_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlws_pkg::engine_cfg_t cfg,
    input  tlws_pkg::restart_t    restart,
    input  logic                  q_empty,
    input  tlws_pkg::item_kind_t  head_kind,
    output logic                  pop,
    tlws_out_if.source            seg_out
);

    localparam int LB = tlws_pkg::LINE_BITS;
    localparam int OB = tlws_pkg::OFFSET_BITS;

    logic [POS_BITS-1:0] cursor_reg, cursor_next;
    logic [POS_BITS-1:0] seg_begin_reg, seg_begin_next;
    logic [LB-1:0]       line_cnt_reg, line_cnt_next;
    logic [LB-1:0]       seg_cnt_reg, seg_cnt_next;
    logic                stopped_reg, stopped_next;

    logic                out_valid_reg;
    logic [LB-1:0]       out_line_reg;
    logic [OB-1:0]       out_start_reg;
    logic [OB-1:0]       out_len_reg;
    logic                out_done_reg;

    logic [POS_BITS-1:0] seg_span;
    logic [POS_BITS-1:0] cursor_inc;
    logic [LB:0]         seg_inc;
    logic [LB:0]         line_inc;
    logic                limit_hit;
    logic                wrap_hit;
    logic                emit;
    logic                emit_done;
    logic [POS_BITS-1:0] restart_pos;

    // Take the head item when the output register is free or draining.
    assign pop = !q_empty && (!out_valid_reg || seg_out.ready);

    // Per-item arithmetic: distance from segment start and the limit checks.
    assign seg_span    = cursor_reg - seg_begin_reg;
    assign cursor_inc  = cursor_reg + 1'b1;
    assign seg_inc     = {1'b0, seg_cnt_reg} + 1'b1;
    assign line_inc    = {1'b0, line_cnt_reg} + 1'b1;
    assign limit_hit   = (seg_cnt_reg >= cfg.max_segments) || (line_cnt_reg >= cfg.max_lines);
    assign wrap_hit    = (cfg.wrap_width != '0) &&
                         (32'(seg_span) >= 32'(cfg.wrap_width - 1'b1));
    assign restart_pos = POS_BITS'(restart.position);

    // Segment state update for one item.
    always_comb
    begin
        cursor_next    = cursor_reg;
        seg_begin_next = seg_begin_reg;
        line_cnt_next  = line_cnt_reg;
        seg_cnt_next   = seg_cnt_reg;
        stopped_next   = stopped_reg;
        emit           = 1'b0;
        emit_done      = 1'b0;
        if (restart.valid)
        begin
            cursor_next    = restart_pos;
            seg_begin_next = restart_pos;
            line_cnt_next  = '0;
            seg_cnt_next   = '0;
            stopped_next   = 1'b0;
        end
        else if (pop && !stopped_reg)
        begin
            if (limit_hit)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                unique case (head_kind)
                    tlws_pkg::KIND_END:
                    begin
                        emit         = 1'b1;
                        emit_done    = 1'b1;
                        seg_cnt_next = seg_inc[LB-1:0];
                        stopped_next = 1'b1;
                    end
                    tlws_pkg::KIND_NEWLINE:
                    begin
                        emit           = 1'b1;
                        emit_done      = (seg_inc >= {1'b0, cfg.max_segments}) ||
                                         (line_inc >= {1'b0, cfg.max_lines});
                        seg_cnt_next   = seg_inc[LB-1:0];
                        line_cnt_next  = line_inc[LB-1:0];
                        seg_begin_next = cursor_inc;
                        cursor_next    = cursor_inc;
                        stopped_next   = emit_done;
                    end
                    tlws_pkg::KIND_PRINT:
                    begin
                        if (wrap_hit)
                        begin
                            emit           = 1'b1;
                            emit_done      = (seg_inc >= {1'b0, cfg.max_segments}) ||
                                             (line_cnt_reg >= cfg.max_lines);
                            seg_cnt_next   = seg_inc[LB-1:0];
                            seg_begin_next = cursor_reg;
                            stopped_next   = emit_done;
                        end
                        cursor_next = cursor_inc;
                    end
                    tlws_pkg::KIND_OTHER:
                    begin
                        cursor_next = cursor_inc;
                    end
                    default:
                    begin
                        cursor_next = cursor_reg;
                    end
                endcase
            end
        end
    end

    // Segment state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= POS_BITS'(tlws_pkg::START_POS_RESET);
            seg_begin_reg <= POS_BITS'(tlws_pkg::START_POS_RESET);
            line_cnt_reg  <= '0;
            seg_cnt_reg   <= '0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            seg_begin_reg <= seg_begin_next;
            line_cnt_reg  <= line_cnt_next;
            seg_cnt_reg   <= seg_cnt_next;
            stopped_reg   <= stopped_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (seg_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output record payload, offsets cut to the record's field width.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_line_reg  <= line_cnt_reg;
            out_start_reg <= OB'(32'(seg_begin_reg));
            out_len_reg   <= OB'(32'(seg_span));
            out_done_reg  <= emit_done;
        end
    end

    assign seg_out.valid          = out_valid_reg;
    assign seg_out.line_number    = out_line_reg;
    assign seg_out.segment_start  = out_start_reg;
    assign seg_out.segment_length = out_len_reg;
    assign seg_out.run_done       = out_done_reg;

endmodule

// ----- design/text_line_wrap_segmenter.sv -----
// Channel   Role    Payload
// text_in   sink    text_byte[7:0], end_marker
// seg_out   source  line_number[15:0], segment_start[23:0], segment_length[23:0], run_done
// cfg_*     write   cfg_index[1:0] selects the register, cfg_data[23:0]
//
// One item is taken per cycle unless the queue is empty or seg_out stalls; a record
// appears in the cycle after its pop; the engine's subtract and compare are combinational.
// Reset (rst_n low, asynchronous) restores register defaults and starts a run at offset zero.
// A stall on seg_out holds the output register; the four-entry queue keeps text_in
// moving until it fills, then text_in.ready drops.
module text_line_wrap_segmenter
#(
    parameter int POS_BITS = tlws_pkg::POS_BITS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    tlws_in_if.sink                              text_in,
    tlws_out_if.source                           seg_out,
    input  logic                                 cfg_we,
    input  logic [tlws_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tlws_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic [tlws_pkg::WIDTH_BITS-1:0]  wrap_width_reg;
    logic [tlws_pkg::LIMIT_BITS-1:0]  max_segments_reg;
    logic [tlws_pkg::LIMIT_BITS-1:0]  max_lines_reg;

    tlws_pkg::engine_cfg_t            engine_cfg;
    tlws_pkg::restart_t               restart;
    tlws_pkg::queue_status_t          q_status;
    tlws_pkg::item_kind_t             push_kind;
    tlws_pkg::item_kind_t             head_kind;
    logic                             push;
    logic                             pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_width_reg   <= tlws_pkg::WRAP_WIDTH_RESET;
            max_segments_reg <= tlws_pkg::MAX_SEGMENTS_RESET;
            max_lines_reg    <= tlws_pkg::MAX_LINES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tlws_pkg::cfg_reg_t'(cfg_index))
                tlws_pkg::REG_WRAP_WIDTH:
                begin
                    wrap_width_reg <= cfg_data[tlws_pkg::WIDTH_BITS-1:0];
                end
                tlws_pkg::REG_START_POSITION:
                begin
                    wrap_width_reg <= wrap_width_reg;
                end
                tlws_pkg::REG_MAX_SEGMENTS:
                begin
                    max_segments_reg <= cfg_data[tlws_pkg::LIMIT_BITS-1:0];
                end
                tlws_pkg::REG_MAX_LINES:
                begin
                    max_lines_reg <= cfg_data[tlws_pkg::LIMIT_BITS-1:0];
                end
                default:
                begin
                    wrap_width_reg <= wrap_width_reg;
                end
            endcase
        end
    end

    // A start position write restarts the run in the segment engine.
    assign restart.valid    = cfg_we &&
                              (tlws_pkg::cfg_reg_t'(cfg_index) == tlws_pkg::REG_START_POSITION);
    assign restart.position = cfg_data;

    assign engine_cfg.wrap_width   = wrap_width_reg;
    assign engine_cfg.max_segments = max_segments_reg;
    assign engine_cfg.max_lines    = max_lines_reg;

    tlws_front u_front
    (
        .text_in   (text_in),
        .q_status  (q_status),
        .push      (push),
        .push_kind (push_kind)
    );

    tlws_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_kind (push_kind),
        .pop       (pop),
        .head_kind (head_kind),
        .status    (q_status)
    );

    tlws_back
    #(
        .POS_BITS (POS_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (engine_cfg),
        .restart   (restart),
        .q_empty   (q_status.empty),
        .head_kind (head_kind),
        .pop       (pop),
        .seg_out   (seg_out)
    );

    // The queue is never full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue flags full and empty together");

    // The engine only takes an item that is present.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // Once the final record of a run is transferred, no further record follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seg_out.valid && seg_out.ready && seg_out.run_done) |=> !seg_out.valid)
        else $error("record presented after the run ended");

endmodule

// ----- dv/text_line_wrap_segmenter_checker.sv -----
module text_line_wrap_segmenter_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    tlws_in_if                                  text_mon,
    tlws_out_if                                 seg_mon,
    input  logic                                cfg_we,
    input  logic [tlws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tlws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  records_checked
);

    import tlws_pkg::*;

    // One segment record as the block should emit it.
    typedef struct packed {
        logic [LINE_BITS-1:0]   line_number;
        logic [OFFSET_BITS-1:0] segment_start;
        logic [OFFSET_BITS-1:0] segment_length;
        logic                   run_done;
    } segment_rec_t;

    segment_rec_t expected_segments[$];
    segment_rec_t want;

    // Shadow copy of the registers.
    logic [WIDTH_BITS-1:0]  wrap_w;
    logic [OFFSET_BITS-1:0] start_pos;
    logic [LIMIT_BITS-1:0]  seg_limit;
    logic [LIMIT_BITS-1:0]  line_limit;

    // Shadow copy of the run state.
    logic [OFFSET_BITS-1:0] cursor;
    logic [OFFSET_BITS-1:0] seg_begin;
    int                     line_count;
    int                     seg_count;
    bit                     halted;

    int mismatches = 0;
    int records_seen = 0;

    assign fail_count      = mismatches;
    assign pending_count   = expected_segments.size();
    assign records_checked = records_seen;

    // A new run begins at the configured start offset.
    function automatic void restart_run();
        cursor     = start_pos;
        seg_begin  = start_pos;
        line_count = 0;
        seg_count  = 0;
        halted     = 1'b0;
    endfunction

    function automatic void queue_segment(input logic [OFFSET_BITS-1:0] length,
                                          input logic done);
        segment_rec_t rec;
        rec.line_number    = line_count[LINE_BITS-1:0];
        rec.segment_start  = seg_begin;
        rec.segment_length = length;
        rec.run_done       = done;
        expected_segments.push_back(rec);
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] value);
        case (cfg_reg_t'(idx))
            REG_WRAP_WIDTH:     wrap_w = value[WIDTH_BITS-1:0];
            REG_START_POSITION:
            begin
                start_pos = value[OFFSET_BITS-1:0];
                restart_run();
            end
            REG_MAX_SEGMENTS:   seg_limit = value[LIMIT_BITS-1:0];
            REG_MAX_LINES:      line_limit = value[LIMIT_BITS-1:0];
            default:            ;
        endcase
    endfunction

    // Advance the segmenter by one text byte and queue the record it closes, if any.
    function automatic void advance_segmenter(input logic [BYTE_BITS-1:0] value,
                                              input logic ends);
        logic [OFFSET_BITS-1:0] span;
        bit                     closes;
        if (halted)
            return;
        // A limit that is already met stops the run without a record.
        if (seg_count >= seg_limit || line_count >= line_limit)
        begin
            halted = 1'b1;
            return;
        end
        span = cursor - seg_begin;
        if (ends)
        begin
            queue_segment(span, 1'b1);
            seg_count++;
            halted = 1'b1;
            return;
        end
        if (value == NEWLINE_BYTE)
        begin
            seg_count++;
            closes = seg_count >= seg_limit || line_count + 1 >= line_limit;
            queue_segment(span, closes);
            line_count++;
            cursor    = cursor + 1'b1;
            seg_begin = cursor;
            if (closes)
                halted = 1'b1;
            return;
        end
        // Printable bytes at the wrap column start a new segment on the same line.
        if (wrap_w != 0 && value >= PRINT_LOW && value <= PRINT_HIGH &&
            span >= wrap_w - 1'b1)
        begin
            seg_count++;
            closes = seg_count >= seg_limit || line_count >= line_limit;
            queue_segment(span, closes);
            seg_begin = cursor;
            cursor    = cursor + 1'b1;
            if (closes)
                halted = 1'b1;
            return;
        end
        cursor = cursor + 1'b1;
    endfunction

    task automatic compare_field(input string name, input logic [OFFSET_BITS-1:0] exp_val,
                                 input logic [OFFSET_BITS-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val,
                     act_val);
            mismatches++;
        end
    endtask

    // Register writes, input transfers and output transfers, all sampled at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_w     = WRAP_WIDTH_RESET;
            start_pos  = START_POS_RESET;
            seg_limit  = MAX_SEGMENTS_RESET;
            line_limit = MAX_LINES_RESET;
            restart_run();
            expected_segments.delete();
        end
        else
        begin
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            if (text_mon.valid && text_mon.ready)
                advance_segmenter(text_mon.text_byte, text_mon.end_marker);
            if (seg_mon.valid && seg_mon.ready)
            begin
                records_seen++;
                if (expected_segments.size() == 0)
                begin
                    $display({"%0t: unexpected record: expected none, ",
                              "actual line %0d start %h len %0d done %b"},
                             $time, seg_mon.line_number, seg_mon.segment_start,
                             seg_mon.segment_length, seg_mon.run_done);
                    mismatches++;
                end
                else
                begin
                    want = expected_segments.pop_front();
                    compare_field("line_number", OFFSET_BITS'(want.line_number),
                                  OFFSET_BITS'(seg_mon.line_number));
                    compare_field("segment_start", want.segment_start, seg_mon.segment_start);
                    compare_field("segment_length", want.segment_length,
                                  seg_mon.segment_length);
                    compare_field("run_done", OFFSET_BITS'(want.run_done),
                                  OFFSET_BITS'(seg_mon.run_done));
                end
            end
        end
    end

endmodule

// ----- dv/text_line_wrap_segmenter_test.sv -----
module text_line_wrap_segmenter_test;

    import tlws_pkg::*;

    localparam int ITEM_TARGET   = 950;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int  fail_count;
    int  pending_count;
    int  records_checked;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  live_items = 0;
    int  runs_started = 0;
    bit  steady = 1'b0;
    bit  run_open;
    int  text_len;

    tlws_in_if  text_ch ();
    tlws_out_if seg_ch ();

    text_line_wrap_segmenter u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_ch),
        .seg_out   (seg_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    text_line_wrap_segmenter_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_mon        (text_ch),
        .seg_mon         (seg_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .records_checked (records_checked)
    );

    // Clock with a period of four units.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls before each transfer, none during steady stretches.
    initial
    begin
        int stall;
        seg_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                seg_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            seg_ch.ready <= 1'b1;
            @(posedge clk);
            while (!seg_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Offer one text item after a random gap and hold it until the transfer.
    task automatic push_text(input logic [BYTE_BITS-1:0] value, input logic ends);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= value;
        text_ch.end_marker <= ends;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_text(s[i], 1'b0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Full setup of a run; the start offset goes last and restarts the run.
    task automatic program_run(input logic [WIDTH_BITS-1:0] ww, input logic [OFFSET_BITS-1:0] sp,
                               input logic [LIMIT_BITS-1:0] ms, input logic [LIMIT_BITS-1:0] ml);
        write_reg(REG_WRAP_WIDTH, CFG_DATA_BITS'(ww));
        write_reg(REG_MAX_SEGMENTS, CFG_DATA_BITS'(ms));
        write_reg(REG_MAX_LINES, CFG_DATA_BITS'(ml));
        write_reg(REG_START_POSITION, CFG_DATA_BITS'(sp));
        cfg_we <= 1'b0;
        runs_started++;
    endtask

    // Drop valid, wait for every pending record and let the input queue drain.
    task automatic settle();
        text_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly printable text with newlines, some control and high bytes.
    function automatic logic [BYTE_BITS-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return NEWLINE_BYTE;
        else if (r < 72)
            return BYTE_BITS'($urandom_range(32, 127));
        else if (r < 80)
            return BYTE_BITS'($urandom_range(0, 31));
        else
            return BYTE_BITS'($urandom_range(0, 255));
    endfunction

    // Narrow widths most of the time so that wrapping happens often.
    function automatic logic [WIDTH_BITS-1:0] pick_wrap();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return 12'd4095;
        else if (r == 2)
            return WIDTH_BITS'($urandom_range(0, 4095));
        else if (r < 6)
            return 12'd1;
        else
            return WIDTH_BITS'($urandom_range(2, 16));
    endfunction

    function automatic logic [LIMIT_BITS-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r < 4)
            return LIMIT_BITS'($urandom_range(1, 6));
        else if (r < 7)
            return LIMIT_BITS'($urandom_range(0, 65535));
        else
            return 16'hFFFF;
    endfunction

    // Reset, directed cases, then random runs.
    initial
    begin
        logic [OFFSET_BITS-1:0] sp;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_WRAP_WIDTH;
        cfg_data           = '0;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.end_marker = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: newlines, an empty line, byte extremes, end marker, then an ignored byte.
        send_text("Hi\n\n");
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b0);
        push_text(8'h7F, 1'b0);
        push_text(8'h20, 1'b0);
        push_text(8'h80, 1'b0);
        push_text(8'hA5, 1'b1);
        push_text("x", 1'b0);
        settle();

        // Width of one cell wraps at every printable byte; offsets roll over.
        program_run(12'd1, 24'hFFFFFE, 16'hFFFF, 16'hFFFF);
        send_text("A\nB");
        push_text(8'h5A, 1'b1);
        settle();

        // Zero width never wraps; the segment limit ends the run on a newline.
        program_run(12'd0, 24'h000100, 16'd2, 16'hFFFF);
        send_text("ab\nc\nz");
        settle();

        // A zero segment limit stops the run silently.
        program_run(12'd4095, 24'h800000, 16'd0, 16'd1);
        send_text("q");
        settle();

        // The line limit ends the run after a wrapped segment.
        program_run(12'd3, 24'h5A5A5A, 16'd3, 16'd1);
        send_text("abcd\n");
        settle();

        // Random runs, some left open and continued with changed limits or width.
        run_open = 1'b0;
        while (live_items < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if (run_open && $urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       write_reg(REG_WRAP_WIDTH, CFG_DATA_BITS'(pick_wrap()));
                    1:       write_reg(REG_MAX_SEGMENTS, CFG_DATA_BITS'(pick_limit()));
                    default: write_reg(REG_MAX_LINES, CFG_DATA_BITS'(pick_limit()));
                endcase
                cfg_we <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       sp = '0;
                    1:       sp = OFFSET_BITS'(24'hFFFFFF - $urandom_range(0, 40));
                    default: sp = OFFSET_BITS'($urandom_range(0, 24'hFFFFFF));
                endcase
                program_run(pick_wrap(), sp, pick_limit(), pick_limit());
            end
            text_len = $urandom_range(4, 50);
            repeat (text_len)
            begin
                push_text(pick_byte(), 1'b0);
                live_items++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                push_text(BYTE_BITS'($urandom_range(0, 255)), 1'b1);
                live_items++;
                run_open = 1'b0;
                // Items after the end of a run must be ignored.
                repeat ($urandom_range(0, 2))
                    push_text(pick_byte(), 1'($urandom_range(0, 1)));
            end
            else
            begin
                run_open = 1'b1;
            end
            settle();
        end

        $display("Covered %0d text transfers over %0d configured runs; %0d records compared.",
                 items_sent, runs_started, records_checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
design/tlws_pkg.sv
design/tlws_in_if.sv
design/tlws_out_if.sv
design/tlws_front.sv
design/tlws_queue.sv
design/tlws_back.sv
design/text_line_wrap_segmenter.sv
dv/text_line_wrap_segmenter_checker.sv
dv/text_line_wrap_segmenter_test.sv
